// File: hw/rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants of the escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // digit width of the shared multiplier (operand bits taken per cycle)
    localparam int DIGIT_W     = 16;

    localparam int GRAY_W      = 8;
    localparam int ESC_W       = 6;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAY_SCALE = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_RSQ = 8'd2;

    localparam int                MAX_ITER_RST   = 100;
    localparam logic [GRAY_W-1:0] GRAY_SCALE_RST = 8'd200;
    localparam logic [ESC_W-1:0]  ESCAPE_RSQ_RST = 6'd16;
    localparam logic [GRAY_W-1:0] GRAY_FULL      = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_EVAL,
        ST_UPDATE,
        ST_GRAY_MUL,
        ST_DIV_WAIT,
        ST_FINISH
    } mbe_state_t;

    typedef enum logic [1:0] {
        PROD_RR,
        PROD_II,
        PROD_RI
    } prod_sel_t;

endpackage

// File: hw/rtl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration of z = z*z + c for one point per word.
// ----------------------------------------------------------------------------
// Each input word is one point c in signed fixed point (FRAC_BITS fraction
// bits). The block iterates z = z*z + c from z = 0 with saturation, stops on
// |z|^2 >= escape_radius_sq or after max_iterations updates, and returns the
// update count, the escape flag and gray = 255 - (n+1)*gray_scale/max_iterations
// clamped at 0. One point is in flight at a time; s_tready is high only
// between points, while a finished result may still wait at the output.
// The three products of every iteration run on one shared multiplier that
// works through the ceil(COORD_WIDTH/16) digits of its second operand in turn;
// after the last iteration a bit-serial divider works out the gray level.
module mandelbrot_escape_time #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28,
    parameter int ITER_WIDTH  = 12
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    // c_real, c_imag
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,

    output logic m_tvalid,
    input  logic m_tready,
    // gray_level, iterations_done, escaped
    output logic [((ITER_WIDTH+9+7)/8)*8-1:0] m_tdata,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mbe_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int OUT_W  = ((ITER_WIDTH+9+7)/8)*8;
    localparam int PROD_W = 2*W;
    localparam int DW     = 2*W + 1;
    localparam int VW     = 2*W + 2;
    localparam int SUM_W  = (2*W + 1 > 2*FRAC_BITS + ESC_W) ? 2*W + 1 : 2*FRAC_BITS + ESC_W;
    localparam int NUM_W  = ITER_WIDTH + 1 + GRAY_W;

    localparam logic signed [VW-1:0] SAT_HI = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [VW-1:0] SAT_LO = ~SAT_HI;

    // configuration
    logic [ITER_WIDTH-1:0] max_iter_reg;
    logic [GRAY_W-1:0]     gray_scale_reg;
    logic [ESC_W-1:0]      esc_rsq_reg;

    mbe_state_t state_reg, state_next;
    prod_sel_t  sel_reg, sel_next;

    logic [ITER_WIDTH-1:0]   n_reg, n_next;
    logic signed [W-1:0]     cr_reg, cr_next;
    logic signed [W-1:0]     ci_reg, ci_next;
    logic [W-1:0]            mag_r_reg, mag_r_next;
    logic [W-1:0]            mag_i_reg, mag_i_next;
    logic                    sgn_r_reg, sgn_r_next;
    logic                    sgn_i_reg, sgn_i_next;
    logic [PROD_W-1:0]       rr_reg, rr_next;
    logic [PROD_W-1:0]       ii_reg, ii_next;
    logic [PROD_W-1:0]       ri_reg, ri_next;
    logic signed [DW-1:0]    diff_reg, diff_next;
    logic signed [DW-1:0]    ris_reg, ris_next;
    logic                    esc_reg, esc_next;
    logic [GRAY_W-1:0]       gray_reg, gray_next;
    logic [GRAY_W-1:0]       gray_out_reg, gray_out_next;
    logic [ITER_WIDTH-1:0]   n_out_reg, n_out_next;
    logic                    esc_out_reg, esc_out_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    logic                    mult_start;
    logic [W-1:0]            mult_a;
    logic [W-1:0]            mult_b;
    logic                    mult_done;
    logic [PROD_W-1:0]       mult_prod;

    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quo;

    logic [SUM_W-1:0]        mag_sum;
    logic [SUM_W-1:0]        esc_limit;
    logic                    esc_hit;
    logic [DW-1:0]           ri_ext;
    logic signed [DW-1:0]    shr_r;
    logic signed [DW-1:0]    shr_i;
    logic signed [VW-1:0]    nr_full;
    logic signed [VW-1:0]    ni_full;
    logic [W-1:0]            zr_sat;
    logic [W-1:0]            zi_sat;
    logic [ITER_WIDTH:0]     n_plus;

    function automatic logic [W-1:0] saturate(input logic signed [VW-1:0] v);
        logic [W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[W-1:0];
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    mbe_mult #(
        .OP_W (W)
    ) u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mult_start),
        .a_mag   (mult_a),
        .b_mag   (mult_b),
        .done    (mult_done),
        .product (mult_prod)
    );

    mbe_div #(
        .NUM_W (NUM_W),
        .DEN_W (ITER_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (max_iter_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // datapath terms
    assign mag_sum   = SUM_W'(rr_reg) + SUM_W'(ii_reg);
    assign esc_limit = SUM_W'(esc_rsq_reg) << (2*FRAC_BITS);
    assign esc_hit   = (mag_sum >= esc_limit);
    assign ri_ext    = {1'b0, ri_reg};
    assign shr_r     = diff_reg >>> FRAC_BITS;
    assign shr_i     = ris_reg >>> (FRAC_BITS - 1);
    assign nr_full   = VW'(shr_r) + VW'(cr_reg);
    assign ni_full   = VW'(shr_i) + VW'(ci_reg);
    assign zr_sat    = saturate(nr_full);
    assign zi_sat    = saturate(ni_full);
    assign n_plus    = {1'b0, n_reg} + (ITER_WIDTH+1)'(1);
    assign div_num   = NUM_W'(n_plus) * NUM_W'(gray_scale_reg);

    always_comb begin
        unique case (sel_reg)
            PROD_RR: begin
                mult_a = mag_r_reg;
                mult_b = mag_r_reg;
            end
            PROD_II: begin
                mult_a = mag_i_reg;
                mult_b = mag_i_reg;
            end
            PROD_RI: begin
                mult_a = mag_r_reg;
                mult_b = mag_i_reg;
            end
            default: begin
                mult_a = mag_r_reg;
                mult_b = mag_r_reg;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        n_next        = n_reg;
        cr_next       = cr_reg;
        ci_next       = ci_reg;
        mag_r_next    = mag_r_reg;
        mag_i_next    = mag_i_reg;
        sgn_r_next    = sgn_r_reg;
        sgn_i_next    = sgn_i_reg;
        rr_next       = rr_reg;
        ii_next       = ii_reg;
        ri_next       = ri_reg;
        diff_next     = diff_reg;
        ris_next      = ris_reg;
        esc_next      = esc_reg;
        gray_next     = gray_reg;
        gray_out_next = gray_out_reg;
        n_out_next    = n_out_reg;
        esc_out_next  = esc_out_reg;
        m_tvalid_next = m_tvalid_reg;
        mult_start    = 1'b0;
        div_start     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cr_next    = s_tdata[W-1:0];
                    ci_next    = s_tdata[2*W-1:W];
                    mag_r_next = '0;
                    mag_i_next = '0;
                    sgn_r_next = 1'b0;
                    sgn_i_next = 1'b0;
                    n_next     = '0;
                    sel_next   = PROD_RR;
                    state_next = ST_MUL_START;
                end
            end
            ST_MUL_START: begin
                mult_start = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mult_done) begin
                    unique case (sel_reg)
                        PROD_RR: begin
                            rr_next    = mult_prod;
                            sel_next   = PROD_II;
                            state_next = ST_MUL_START;
                        end
                        PROD_II: begin
                            ii_next    = mult_prod;
                            sel_next   = PROD_RI;
                            state_next = ST_MUL_START;
                        end
                        PROD_RI: begin
                            ri_next    = mult_prod;
                            state_next = ST_EVAL;
                        end
                        default: begin
                            sel_next   = PROD_RR;
                            state_next = ST_MUL_START;
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                diff_next = {1'b0, rr_reg} - {1'b0, ii_reg};
                ris_next  = (sgn_r_reg ^ sgn_i_reg) ? (~ri_ext + DW'(1)) : ri_ext;
                esc_next  = esc_hit;
                if (esc_hit || (n_reg >= max_iter_reg)) begin
                    state_next = ST_GRAY_MUL;
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                sgn_r_next = zr_sat[W-1];
                sgn_i_next = zi_sat[W-1];
                mag_r_next = zr_sat[W-1] ? (~zr_sat + W'(1)) : zr_sat;
                mag_i_next = zi_sat[W-1] ? (~zi_sat + W'(1)) : zi_sat;
                n_next     = n_reg + ITER_WIDTH'(1);
                sel_next   = PROD_RR;
                state_next = ST_MUL_START;
            end
            ST_GRAY_MUL: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if ((max_iter_reg == '0) || (div_quo >= NUM_W'(GRAY_FULL))) begin
                        gray_next = '0;
                    end else begin
                        gray_next = GRAY_FULL - div_quo[GRAY_W-1:0];
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    gray_out_next = gray_reg;
                    n_out_next    = n_reg;
                    esc_out_next  = esc_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sel_reg      <= PROD_RR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sel_reg      <= sel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        cr_reg       <= cr_next;
        ci_reg       <= ci_next;
        mag_r_reg    <= mag_r_next;
        mag_i_reg    <= mag_i_next;
        sgn_r_reg    <= sgn_r_next;
        sgn_i_reg    <= sgn_i_next;
        rr_reg       <= rr_next;
        ii_reg       <= ii_next;
        ri_reg       <= ri_next;
        diff_reg     <= diff_next;
        ris_reg      <= ris_next;
        esc_reg      <= esc_next;
        gray_reg     <= gray_next;
        gray_out_reg <= gray_out_next;
        n_out_reg    <= n_out_next;
        esc_out_reg  <= esc_out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg   <= ITER_WIDTH'(MAX_ITER_RST);
            gray_scale_reg <= GRAY_SCALE_RST;
            esc_rsq_reg    <= ESCAPE_RSQ_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_MAX_ITER) begin
                max_iter_reg <= cfg_data[ITER_WIDTH-1:0];
            end
            if (cfg_index == REG_GRAY_SCALE) begin
                gray_scale_reg <= cfg_data[GRAY_W-1:0];
            end
            if (cfg_index == REG_ESCAPE_RSQ) begin
                esc_rsq_reg <= cfg_data[ESC_W-1:0];
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_W'({esc_out_reg, n_out_reg, gray_out_reg});

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL_START && n_reg == '0))
        else $error("accepted word did not start a fresh iteration");

    a_mult_done_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        mult_done |-> (state_reg == ST_MUL_WAIT))
        else $error("multiplier finished outside of a product wait");

    a_div_done_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside of the gray step");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && m_tvalid && !m_tready) |=> (state_reg == ST_FINISH))
        else $error("pending output word overwritten");

endmodule

// File: hw/rtl/mbe_mult.sv
// ----------------------------------------------------------------------------
// mbe_mult
// Shared unsigned multiplier, one DIGIT_W-bit digit of b per cycle.
// ----------------------------------------------------------------------------
module mbe_mult #(
    parameter int OP_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [OP_W-1:0]   a_mag,
    input  logic [OP_W-1:0]   b_mag,
    output logic              done,
    output logic [2*OP_W-1:0] product
);
    import mbe_pkg::*;

    localparam int DIGITS = (OP_W + DIGIT_W - 1) / DIGIT_W;
    localparam int BW     = DIGITS * DIGIT_W;
    localparam int PW     = BW + OP_W;
    localparam int SW     = OP_W + DIGIT_W;
    localparam int CNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic [OP_W-1:0]  a_reg;
    logic [BW-1:0]    b_reg;
    logic [PW-1:0]    acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [SW-1:0]    partial;
    logic [SW-1:0]    sum;
    logic [PW-1:0]    acc_next;
    logic             last;

    assign partial  = SW'(a_reg) * SW'(b_reg[DIGIT_W-1:0]);
    assign sum      = SW'(acc_reg[PW-1:BW]) + partial;
    assign acc_next = PW'({sum, acc_reg[BW-1:0]} >> DIGIT_W);
    assign last     = (cnt_reg == CNT_W'(DIGITS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a_mag;
            b_reg   <= BW'(b_mag);
            acc_reg <= '0;
        end else if (busy_reg) begin
            b_reg   <= b_reg >> DIGIT_W;
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg[2*OP_W-1:0];

endmodule

// File: hw/rtl/mbe_div.sv
// ----------------------------------------------------------------------------
// mbe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbe_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign fits      = (trial >= {1'b0, den_reg});
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: test/tb_mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time
// Self-checking bench for the escape-time block.
// ----------------------------------------------------------------------------
// Points go in on the slave stream. Each accepted point is run through a local
// fixed-point model of the z = z*z + c iteration under a mirror of the three
// registers. The expected count, escape flag and gray level are queued and
// compared field by field with every word taken from the master stream. The
// run covers corner points, zero budget and zero escape limit, the widest
// budget, and several register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time;
    timeunit 1ns;
    timeprecision 1ps;

    import mbe_pkg::*;

    localparam int COORD_W     = 32;
    localparam int FRAC_W      = 28;
    localparam int ITER_W      = 12;
    localparam int S_DATA_W    = ((2 * COORD_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((ITER_W + 9 + 7) / 8) * 8;
    localparam int ONE         = 1 << FRAC_W;
    localparam int QUIET_LIMIT = 300000;
    localparam int TAIL_CYCLES = 64;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic [ITER_W-1:0] iters;
        logic              escaped;
    } pixel_t;

    class pixel_checker;
        logic [ITER_W-1:0] max_iter;
        logic [GRAY_W-1:0] gray_scale;
        logic [ESC_W-1:0]  escape_rsq;
        pixel_t            pending_pixels[$];
        int                errors;

        function new();
            max_iter   = ITER_W'(MAX_ITER_RST);
            gray_scale = GRAY_SCALE_RST;
            escape_rsq = ESCAPE_RSQ_RST;
            errors     = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            unique case (index)
                REG_MAX_ITER:   max_iter   = data[ITER_W-1:0];
                REG_GRAY_SCALE: gray_scale = data[GRAY_W-1:0];
                REG_ESCAPE_RSQ: escape_rsq = data[ESC_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [COORD_W-1:0] clamp(logic signed [127:0] v);
            logic signed [127:0] top, bottom;
            top    = {1'b0, {(COORD_W-1){1'b1}}};
            bottom = -top - 1;
            if (v > top)
                return top[COORD_W-1:0];
            if (v < bottom)
                return bottom[COORD_W-1:0];
            return v[COORD_W-1:0];
        endfunction

        function pixel_t escape_time(logic signed [COORD_W-1:0] cr,
                                     logic signed [COORD_W-1:0] ci);
            logic signed [COORD_W-1:0] zr, zi;
            logic signed [127:0]       rr, ii, ri, nr, ni, mag, limit;
            int unsigned               n, q;
            logic                      esc;
            pixel_t                    px;
            zr    = '0;
            zi    = '0;
            n     = 0;
            limit = escape_rsq;
            limit = limit << (2 * FRAC_W);
            esc   = (limit == 0);
            while (!esc && n < max_iter) begin
                rr  = zr * zr;
                ii  = zi * zi;
                ri  = zr * zi;
                nr  = ((rr - ii) >>> FRAC_W) + cr;
                ni  = (ri >>> (FRAC_W - 1)) + ci;
                zr  = clamp(nr);
                zi  = clamp(ni);
                n++;
                mag = zr * zr + zi * zi;
                esc = (mag >= limit);
            end
            if (max_iter == 0) begin
                px.gray = '0;
            end else begin
                q = ((n + 1) * gray_scale) / max_iter;
                px.gray = (q >= GRAY_FULL) ? '0 : GRAY_FULL - q[GRAY_W-1:0];
            end
            px.iters   = n[ITER_W-1:0];
            px.escaped = esc;
            return px;
        endfunction

        function void note_point(logic [S_DATA_W-1:0] word);
            pending_pixels.insert(pending_pixels.size(),
                                  escape_time(word[COORD_W-1:0],
                                              word[2*COORD_W-1:COORD_W]));
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [M_DATA_W-1:0] word);
            pixel_t got, want;
            got.gray    = word[GRAY_W-1:0];
            got.iters   = word[GRAY_W+ITER_W-1:GRAY_W];
            got.escaped = word[GRAY_W+ITER_W];
            if (pending_pixels.size() == 0) begin
                report($sformatf("result word %h with no point pending", word));
            end else begin
                want = pending_pixels.pop_front();
                if (got.gray !== want.gray)
                    report($sformatf("gray_level %0d, want %0d", got.gray, want.gray));
                if (got.iters !== want.iters)
                    report($sformatf("iterations_done %0d, want %0d",
                                     got.iters, want.iters));
                if (got.escaped !== want.escaped)
                    report($sformatf("escaped %b, want %b", got.escaped, want.escaped));
            end
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;   // c_real, c_imag
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;          // gray_level, iterations_done, escaped
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    pixel_checker sb;
    int send_idle_pct = 12;
    int recv_idle_pct = 69;
    int hold_cycles   = 0;
    int quiet_cycles  = 0;

    mandelbrot_escape_time #(
        .COORD_WIDTH (COORD_W),
        .FRAC_BITS   (FRAC_W),
        .ITER_WIDTH  (ITER_W)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // receiver: long hold-off when requested, random stalls otherwise
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_point(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("mandelbrot_escape_time test failed");
            $finish;
        end
    end

    task automatic send_point(input logic [S_DATA_W-1:0] word);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // junk in the unused upper bits, plus one write to an unmapped index
    task automatic configure(input int budget, input int scale, input int rsq);
        write_reg(REG_MAX_ITER,   {4'($urandom()), 12'(budget)});
        write_reg(REG_GRAY_SCALE, {8'($urandom()), 8'(scale)});
        write_reg(REG_ESCAPE_RSQ, {10'($urandom()), 6'(rsq)});
        write_reg(8'($urandom_range(255, REG_ESCAPE_RSQ + 1)), 16'($urandom()));
    endtask

    function automatic logic [S_DATA_W-1:0] random_point();
        logic [COORD_W-1:0] cr, ci;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 75) begin
            cr = $urandom_range(3 * ONE) - 9 * (ONE / 4);
            ci = $urandom_range(3 * ONE) - 3 * (ONE / 2);
        end else if (pick < 90) begin
            cr = $signed($urandom()) >>> 2;
            ci = $signed($urandom()) >>> 2;
        end else begin
            cr = $urandom();
            ci = $urandom();
        end
        return {ci, cr};
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i > 0 && i % 100 == 0)
                wait_idle();
            send_point(random_point());
        end
        wait_idle();
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // corner points under reset settings, words are {imag, real}
        send_point({32'h0000_0000, 32'h0000_0000});
        send_point({32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_point({32'h8000_0000, 32'h8000_0000});
        send_point({32'h0000_0000, 32'h7FFF_FFFF});
        send_point({32'h0000_0000, 32'h8000_0000});
        send_point({32'h7FFF_FFFF, 32'h0000_0000});
        send_point({32'h8000_0000, 32'h0000_0000});
        send_point({32'h0000_0000, 32'hE000_0000});
        send_point({32'h0000_68DB, 32'hE000_0000});
        send_point({32'h0000_0000, 32'h0400_0000});
        send_point({32'h0199_999A, 32'hF400_0000});
        send_point({32'h0000_0000, 32'h1000_0000});
        send_point({32'h1000_0000, 32'h0000_0000});
        send_point({32'h0000_0000, 32'hF000_0000});
        send_point({32'h0000_0000, 32'h4000_0000});
        send_point({32'h4000_0000, 32'h0000_0000});
        send_point({32'h0800_0000, 32'h04CC_CCCD});
        send_point({32'h0A66_6666, 32'hFE66_6666});
        send_point({32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_point({32'h0000_0001, 32'h0000_0001});
        wait_idle();

        configure(100, 200, 16);
        hold_cycles = 2500;
        run_random(300);

        send_idle_pct = 69;
        recv_idle_pct = 12;
        configure(20, 255, 4);
        run_random(300);
        configure(1, 0, 63);
        run_random(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(0, $urandom_range(255), 0);
        run_random(4);
        configure(0, 77, 16);
        run_random(3);
        configure(50, 255, 0);
        run_random(3);

        configure(4095, 255, 1);
        send_point({32'h0000_0000, 32'h0000_0000});
        for (int i = 0; i < 4; i++)
            send_point({32'($urandom()), 32'(ONE + $urandom_range(ONE))});
        wait_idle();

        for (int k = 0; k < 4; k++) begin
            configure($urandom_range(64, 1), $urandom_range(255), $urandom_range(63, 1));
            run_random(90);
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
            $display("mandelbrot_escape_time test passed");
        else
            $display("mandelbrot_escape_time test failed");
        $finish;
    end

endmodule
